// ----- src/rtpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpm_pkg: shared types for the routing table prefix match block
// Table depth, index widths, operation and status codes, and the structs
// that travel between the search cells and the controller.
// ----------------------------------------------------------------------------
package rtpm_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DEL    = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_UNREACHABLE = 3'd2,
    ST_DUPLICATE   = 3'd3,
    ST_FULL        = 3'd4,
    ST_EMPTY       = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_PORT0_ADDRESS = 2'd0,
    CFG_PORT0_MASK    = 2'd1,
    CFG_PORT1_ADDRESS = 2'd2,
    CFG_PORT1_MASK    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] target_address;
    logic [31:0] route_mask;
    logic [31:0] next_hop;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        hit;
    logic [31:0] entry_prefix;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [31:0] entry_port;
    logic [4:0]  entry_count;
  } rsp_t;

  // Search record handed from one cell to the next.
  typedef struct packed {
    logic        found;
    idx_t        idx;
    logic [31:0] mask;
    logic [31:0] prefix;
    logic [31:0] gateway;
    logic        port_sel;
    logic        free_found;
    idx_t        free_idx;
  } tok_t;

  // Update broadcast from the controller to all cells.
  typedef struct packed {
    logic        set;
    logic        clr;
    idx_t        idx;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic        port_sel;
  } wr_t;

endpackage

// ----- src/rtpm_cell.sv -----
// ----------------------------------------------------------------------------
// rtpm_cell: one slot of the routing table
// Holds one route and refines the search record passed in from its
// neighbour, registering the result for the next cell.
// ----------------------------------------------------------------------------
module rtpm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtpm_pkg::idx_t     cell_idx_i,
  input  logic [31:0]        addr_i,
  input  rtpm_pkg::tok_t     tok_i,
  output rtpm_pkg::tok_t     tok_o,
  input  rtpm_pkg::wr_t      wr_i,
  output logic               valid_o
);
  import rtpm_pkg::*;

  logic        valid_q;
  logic [31:0] prefix_q;
  logic [31:0] mask_q;
  logic [31:0] gateway_q;
  logic        sel_q;
  tok_t        tok_d, tok_q;
  logic        match, better;

  assign match  = valid_q && ((prefix_q & mask_q) == (addr_i & mask_q));
  assign better = match && (!tok_i.found || (mask_q > tok_i.mask));

  always_comb begin
    tok_d = tok_i;
    if (better) begin
      tok_d.found    = 1'b1;
      tok_d.idx      = cell_idx_i;
      tok_d.mask     = mask_q;
      tok_d.prefix   = prefix_q;
      tok_d.gateway  = gateway_q;
      tok_d.port_sel = sel_q;
    end
    if (!valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.set && (wr_i.idx == cell_idx_i)) begin
        valid_q <= 1'b1;
      end else if (wr_i.clr && (wr_i.idx == cell_idx_i)) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.set && (wr_i.idx == cell_idx_i)) begin
      prefix_q  <= wr_i.prefix;
      mask_q    <= wr_i.mask;
      gateway_q <= wr_i.gateway;
      sel_q     <= wr_i.port_sel;
    end
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

// ----- src/routing_table_prefix_match.sv -----
// ----------------------------------------------------------------------------
// routing_table_prefix_match: IPv4 longest prefix match routing table
// A row of slot cells searched by a record that moves one cell per cycle.
// ----------------------------------------------------------------------------
// Usage. Each request transaction on req_* carries one operation: add a
// route, delete the best route for an address, or look an address up.
// Exactly one response transaction on rsp_* follows each request, in order.
// The search record enters the first cell and moves one cell per clock
// through the row of cells, one slot each; the result is written to the
// output register once the record has left the last cell. Requests are
// taken one at a time: a new one is accepted only after the current search
// has written its result. The response sits in an output register; a new
// request is accepted while it waits, and if the receiver still stalls when
// that next search finishes, the block holds its result until the register
// frees. Interface addresses and masks are written on the cfg_* port, which
// has no handshake; the user must write them only while the block is idle,
// as the block itself does not enforce it. Reset empties the table at once
// (every slot marked invalid) and clears the interface registers to zero.
// ----------------------------------------------------------------------------
module routing_table_prefix_match (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  rtpm_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output rtpm_pkg::rsp_t      rsp_o,
  input  logic                cfg_we_i,
  input  rtpm_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);
  import rtpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e      state_q, state_d;
  req_t        req_q;
  cnt_t        scan_cnt_q;
  cnt_t        valid_cnt_q, valid_cnt_d;
  logic        rsp_valid_q;
  rsp_t        rsp_q, rsp_d;
  logic [31:0] p0_addr_q, p0_mask_q, p1_addr_q, p1_mask_q;

  tok_t                    chain [TableEntries+1];
  logic [TableEntries-1:0] slot_valid;
  wr_t                     wr;
  tok_t                    best;
  logic                    req_fire, scan_done, commit;
  logic                    reach0, reach1;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign scan_done   = (state_q == S_SCAN) && (scan_cnt_q == cnt_t'(TableEntries));
  // The result may be written once the output register is empty or draining.
  assign commit      = scan_done && (!rsp_valid_q || rsp_ready_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_addr_q <= '0;
      p0_mask_q <= '0;
      p1_addr_q <= '0;
      p1_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PORT0_ADDRESS: p0_addr_q <= cfg_wdata_i;
        CFG_PORT0_MASK:    p0_mask_q <= cfg_wdata_i;
        CFG_PORT1_ADDRESS: p1_addr_q <= cfg_wdata_i;
        CFG_PORT1_MASK:    p1_mask_q <= cfg_wdata_i;
        default:           p0_addr_q <= p0_addr_q;
      endcase
    end
  end

  // The row of slot cells. The first cell sees an empty search record.
  assign chain[0] = '0;

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    rtpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (idx_t'(i)),
      .addr_i     (req_q.target_address),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1]),
      .wr_i       (wr),
      .valid_o    (slot_valid[i])
    );
  end

  assign best = chain[TableEntries];

  // The gateway is reachable through the first interface whose subnet holds it.
  assign reach0 = (p0_addr_q & p0_mask_q) == (req_q.next_hop & p0_mask_q);
  assign reach1 = (p1_addr_q & p1_mask_q) == (req_q.next_hop & p1_mask_q);

  // Decision logic, evaluated once the search record has left the last cell.
  always_comb begin
    wr          = '0;
    valid_cnt_d = valid_cnt_q;
    rsp_d       = '0;
    rsp_d.status = ST_OK;

    unique case (req_q.mode)
      MODE_LOOKUP, MODE_DEL: begin
        if (valid_cnt_q == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (!best.found) begin
          rsp_d.status = ST_NOT_FOUND;
        end else begin
          rsp_d.hit           = 1'b1;
          rsp_d.entry_prefix  = best.prefix;
          rsp_d.entry_mask    = best.mask;
          rsp_d.entry_gateway = best.gateway;
          rsp_d.entry_port    = best.port_sel ? p1_addr_q : p0_addr_q;
          if (req_q.mode == MODE_DEL) begin
            wr.clr      = 1'b1;
            wr.idx      = best.idx;
            valid_cnt_d = valid_cnt_q - cnt_t'(1);
          end
        end
      end
      MODE_ADD: begin
        // An existing non-default route for the address blocks the add.
        if (best.found && (best.mask != '0)) begin
          rsp_d.status        = ST_DUPLICATE;
          rsp_d.hit           = 1'b1;
          rsp_d.entry_prefix  = best.prefix;
          rsp_d.entry_mask    = best.mask;
          rsp_d.entry_gateway = best.gateway;
          rsp_d.entry_port    = best.port_sel ? p1_addr_q : p0_addr_q;
        end else if (!reach0 && !reach1) begin
          rsp_d.status = ST_UNREACHABLE;
        end else if (!best.free_found) begin
          rsp_d.status = ST_FULL;
        end else begin
          wr.set              = 1'b1;
          wr.idx              = best.free_idx;
          wr.prefix           = req_q.target_address & req_q.route_mask;
          wr.mask             = req_q.route_mask;
          wr.gateway          = req_q.next_hop;
          wr.port_sel         = !reach0;
          valid_cnt_d         = valid_cnt_q + cnt_t'(1);
          rsp_d.hit           = 1'b1;
          rsp_d.entry_prefix  = req_q.target_address & req_q.route_mask;
          rsp_d.entry_mask    = req_q.route_mask;
          rsp_d.entry_gateway = req_q.next_hop;
          rsp_d.entry_port    = reach0 ? p0_addr_q : p1_addr_q;
        end
      end
      MODE_NOP: begin
        rsp_d.status = ST_OK;
      end
      default: begin
        rsp_d.status = ST_OK;
      end
    endcase

    rsp_d.entry_count = 5'(valid_cnt_d);

    // Updates only take effect on the commit cycle.
    if (!commit) begin
      wr.set = 1'b0;
      wr.clr = 1'b0;
    end
  end

  // Controller state machine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_fire) state_d = S_SCAN;
      S_SCAN:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      valid_cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_fire) begin
        scan_cnt_q <= '0;
      end else if ((state_q == S_SCAN) && !scan_done) begin
        scan_cnt_q <= scan_cnt_q + cnt_t'(1);
      end
      if (commit) begin
        valid_cnt_q <= valid_cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i;
    end
    if (commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // The route count always agrees with the valid bits held in the cells.
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_valid) == 32'(valid_cnt_q))
    else $error("route count differs from the number of valid slots");

  // The count never exceeds the table depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_cnt_q <= cnt_t'(TableEntries))
    else $error("route count beyond table depth");

  // An accepted request always starts a fresh search.
  a_fire_scans : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_SCAN) && (scan_cnt_q == '0))
    else $error("accepted request did not start a search");

  // A response only appears after a completed search.
  a_rsp_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(scan_done))
    else $error("response raised without a finished search");

  // Table updates are never issued outside the commit cycle.
  a_wr_on_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.set || wr.clr) |-> commit && !(wr.set && wr.clr))
    else $error("slot update outside commit");

endmodule

// ----- tb/tb_routing_table_prefix_match.sv -----
// ----------------------------------------------------------------------------
// tb_routing_table_prefix_match: self-checking bench for the routing table
// Sends add, delete, lookup and no-op transactions through the request
// channel and checks every response against a cycle-free model of the table
// that is kept in step with the block, under several interface settings.
// ----------------------------------------------------------------------------
module tb_routing_table_prefix_match;
  timeunit 1ns;
  timeprecision 1ps;

  import rtpm_pkg::*;

  // The settling pause is sized from the table depth.
  localparam int unsigned ResponseLatency = TableEntries + 2;
  localparam int unsigned DrainCycles     = 2 * ResponseLatency;
  localparam int unsigned HoldOffCycles   = 150;
  localparam int unsigned WatchdogLimit   = 3000;
  localparam int unsigned IdlePercent     = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid_i;
  logic        req_ready_o;
  req_t        req_i;
  logic        rsp_valid_o;
  logic        rsp_ready_i;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  routing_table_prefix_match dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Model of the routing table. It is updated at the edge where a request
  // transaction is accepted, which keeps it in the order the block sees.
  // --------------------------------------------------------------------------
  logic        slot_used [TableEntries];
  logic [31:0] slot_pfx  [TableEntries];
  logic [31:0] slot_msk  [TableEntries];
  logic [31:0] slot_gw   [TableEntries];
  logic        slot_sel  [TableEntries];
  logic [4:0]  route_count;
  logic [31:0] port_addr [2];
  logic [31:0] port_msk  [2];

  // Expected responses, oldest first.
  rsp_t        expected_rsp [$];
  rsp_t        want_rsp;

  // Shared controls: no_idle removes all random gaps on both sides, and
  // stall_sink asks the response side for one long hold-off.
  bit          no_idle;
  bit          stall_sink;

  int unsigned ops_sent;
  int unsigned responses_checked;
  int unsigned failures;
  int unsigned status_seen [8];
  int unsigned quiet_cycles;

  // Longest-prefix search: the greatest mask wins, and a strict compare keeps
  // the lowest slot on a tie. Returns -1 when nothing matches.
  function automatic int best_route(input logic [31:0] addr);
    int          pick;
    logic [31:0] pick_mask;
    pick      = -1;
    pick_mask = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (slot_used[i] && ((slot_pfx[i] & slot_msk[i]) == (addr & slot_msk[i]))
          && (pick < 0 || slot_msk[i] > pick_mask)) begin
        pick      = i;
        pick_mask = slot_msk[i];
      end
    end
    return pick;
  endfunction

  // The reported port is the interface register as it stands now, not as it
  // stood when the route was added.
  function automatic rsp_t with_entry(input rsp_t res, input int s);
    rsp_t r;
    r               = res;
    r.hit           = 1'b1;
    r.entry_prefix  = slot_pfx[s];
    r.entry_mask    = slot_msk[s];
    r.entry_gateway = slot_gw[s];
    r.entry_port    = slot_sel[s] ? port_addr[1] : port_addr[0];
    return r;
  endfunction

  function automatic rsp_t apply_route_op(input req_t op);
    rsp_t res;
    int   sel;
    int   free_slot;
    logic gw_port;
    logic reachable;
    res        = '0;
    res.status = ST_OK;
    case (op.mode)
      MODE_LOOKUP, MODE_DEL: begin
        if (route_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          sel = best_route(op.target_address);
          if (sel < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res = with_entry(res, sel);
            if (op.mode == MODE_DEL) begin
              slot_used[sel] = 1'b0;
              route_count    = route_count - 1'b1;
            end
          end
        end
      end
      MODE_ADD: begin
        sel = best_route(op.target_address);
        // Only a non-default match blocks an add; default routes may stack.
        if (sel >= 0 && slot_msk[sel] != '0) begin
          res.status = ST_DUPLICATE;
          res        = with_entry(res, sel);
        end else begin
          reachable = 1'b1;
          gw_port   = 1'b0;
          if ((port_addr[0] & port_msk[0]) == (op.next_hop & port_msk[0])) begin
            gw_port = 1'b0;
          end else if ((port_addr[1] & port_msk[1]) == (op.next_hop & port_msk[1])) begin
            gw_port = 1'b1;
          end else begin
            reachable = 1'b0;
          end
          free_slot = -1;
          for (int i = TableEntries - 1; i >= 0; i--) begin
            if (!slot_used[i]) free_slot = i;
          end
          // Reachability is judged before a full table.
          if (!reachable) begin
            res.status = ST_UNREACHABLE;
          end else if (free_slot < 0) begin
            res.status = ST_FULL;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_pfx[free_slot]  = op.target_address & op.route_mask;
            slot_msk[free_slot]  = op.route_mask;
            slot_gw[free_slot]   = op.next_hop;
            slot_sel[free_slot]  = gw_port;
            route_count          = route_count + 1'b1;
            res                  = with_entry(res, free_slot);
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = route_count;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] contiguous_mask(input int unsigned len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // Mostly ordinary prefixes, some default routes and some scattered masks.
  function automatic logic [31:0] pick_route_mask();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 32'h0;
    if (roll < 15) return $urandom;
    return contiguous_mask($urandom_range(8, 32));
  endfunction

  // Gateways land in one of the two interface subnets most of the time.
  function automatic logic [31:0] pick_gateway();
    int unsigned roll;
    int unsigned p;
    roll = $urandom_range(0, 99);
    if (roll >= 80) return $urandom;
    p = (roll < 40) ? 0 : 1;
    return (port_addr[p] & port_msk[p]) | ($urandom & ~port_msk[p]);
  endfunction

  // With the given likelihood, an address inside a stored route, so that
  // lookups hit, deletes find something and some adds turn out duplicates.
  function automatic logic [31:0] pick_target(input int unsigned reuse_pct);
    int unsigned s;
    if ($urandom_range(0, 99) < reuse_pct) begin
      for (int tries = 0; tries < 4; tries++) begin
        s = $urandom_range(0, TableEntries - 1);
        if (slot_used[s]) return slot_pfx[s] | ($urandom & ~slot_msk[s]);
      end
    end
    return $urandom;
  endfunction

  // Offers one request transaction and predicts its response on acceptance.
  // Valid stays high between back-to-back items; it only drops in a gap.
  task automatic send_op(input mode_e op_mode, input logic [31:0] addr,
                         input logic [31:0] mask, input logic [31:0] gw);
    req_t op;
    op.mode           = op_mode;
    op.target_address = addr;
    op.route_mask     = mask;
    op.next_hop       = gw;
    while (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= op;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    expected_rsp.push_back(apply_route_op(op));
    ops_sent++;
  endtask

  // Drops valid and waits until every response is back and the block has
  // had time to go quiet.
  task automatic settle_block();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all four interface registers, one per cycle, while idle.
  task automatic program_ports(input logic [31:0] a0, input logic [31:0] m0,
                               input logic [31:0] a1, input logic [31:0] m1);
    cfg_idx_e    regs [4];
    logic [31:0] vals [4];
    regs = '{CFG_PORT0_ADDRESS, CFG_PORT0_MASK, CFG_PORT1_ADDRESS, CFG_PORT1_MASK};
    vals = '{a0, m0, a1, m1};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= regs[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    port_addr[0]  = a0;
    port_msk[0]   = m0;
    port_addr[1]  = a1;
    port_msk[1]   = m1;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Lookup and delete on an empty table report empty; a no-op only reports
  // the count.
  task automatic test_empty_table();
    send_op(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_op(MODE_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Adds through each interface, an unreachable gateway, and two adds that the
  // existing /16 route turns into duplicates: a /24 and a /8.
  task automatic test_add_routes();
    send_op(MODE_ADD, 32'hC0A8_1234, 32'hFFFF_0000, 32'h0A00_0002);
    send_op(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hC0A8_01FE);
    send_op(MODE_ADD, 32'h0A0B_0C0D, 32'hFFFF_FF00, 32'h0808_0808);
    send_op(MODE_ADD, 32'hC0A8_0A63, 32'hFFFF_FF00, 32'h0AFF_FFFF);
    send_op(MODE_ADD, 32'hC0A8_0A05, 32'hFF00_0000, 32'h0A00_0002);
  endtask

  // Lookups find the stored routes; a lookup and a delete that miss report not found.
  task automatic test_longest_match();
    send_op(MODE_LOOKUP, 32'hC0A8_0A07, 32'h0, 32'h0);
    send_op(MODE_LOOKUP, 32'hC0A8_1234, 32'h0, 32'h0);
    send_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_op(MODE_LOOKUP, 32'h0102_0304, 32'h0, 32'h0);
    send_op(MODE_DEL, 32'h0000_0000, 32'h0, 32'h0);
  endtask

  // Two default routes may coexist; the lower slot wins the tie.
  task automatic test_default_routes();
    send_op(MODE_ADD, 32'h1234_5678, 32'h0000_0000, 32'h0A00_0003);
    send_op(MODE_ADD, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0102);
    send_op(MODE_LOOKUP, 32'h0102_0304, 32'h0, 32'h0);
  endtask

  // Delete removes the best match only, and a freed slot is reused first.
  task automatic test_delete_routes();
    send_op(MODE_DEL, 32'hC0A8_0A07, 32'h0, 32'h0);
    send_op(MODE_LOOKUP, 32'hC0A8_0A07, 32'h0, 32'h0);
    send_op(MODE_DEL, 32'h0102_0304, 32'h0, 32'h0);
    send_op(MODE_LOOKUP, 32'h0102_0304, 32'h0, 32'h0);
    send_op(MODE_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0004);
  endtask

  // Moves both interfaces to the extremes of their range: stored routes now
  // report the new port address, and new adds pick interfaces accordingly.
  task automatic test_interface_change();
    settle_block();
    program_ports(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_op(MODE_LOOKUP, 32'hC0A8_1234, 32'h0, 32'h0);
    send_op(MODE_ADD, 32'h0B00_0000, 32'hFF00_0000, 32'hFFFF_FFFF);
    send_op(MODE_ADD, 32'h0C00_0000, 32'hFF00_0000, 32'h1234_5678);
  endtask

  // Random operations with the given weights in percent; the rest are
  // no-ops.
  task automatic test_random_mix(input int unsigned count, input int unsigned add_pct,
                                 input int unsigned del_pct, input int unsigned look_pct);
    int unsigned roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct) begin
        send_op(MODE_ADD, pick_target(15), pick_route_mask(), pick_gateway());
      end else if (roll < add_pct + del_pct) begin
        send_op(MODE_DEL, pick_target(75), $urandom, $urandom);
      end else if (roll < add_pct + del_pct + look_pct) begin
        send_op(MODE_LOOKUP, pick_target(70), $urandom, $urandom);
      end else begin
        send_op(MODE_NOP, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // A long stretch with neither side idling, at the full rate of the block.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_mix(40, 35, 30, 30);
    no_idle = 1'b0;
  endtask

  // The receiver holds off while requests keep coming, so the output
  // register and the search both fill and the request side stalls.
  task automatic test_output_backpressure();
    stall_sink = 1'b1;
    test_random_mix(16, 35, 30, 30);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random ready, with one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : response_sink
    int unsigned held;
    rsp_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_sink) begin
        rsp_ready_i <= 1'b0;
        for (held = 1; held < HoldOffCycles; held++) @(posedge clk_i);
        stall_sink = 1'b0;
      end else begin
        rsp_ready_i <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  // Each accepted response transaction is compared with the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      responses_checked++;
      status_seen[rsp_o.status]++;
      if (expected_rsp.size() == 0) begin
        $error("response with no request outstanding: %h", rsp_o);
        failures++;
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (rsp_o.status !== want_rsp.status) begin
          $error("status mismatch: expected %0d, got %0d", want_rsp.status, rsp_o.status);
          failures++;
        end
        if (rsp_o.hit !== want_rsp.hit) begin
          $error("hit mismatch: expected %0d, got %0d", want_rsp.hit, rsp_o.hit);
          failures++;
        end
        if (rsp_o.entry_prefix !== want_rsp.entry_prefix) begin
          $error("entry_prefix mismatch: expected %h, got %h",
                 want_rsp.entry_prefix, rsp_o.entry_prefix);
          failures++;
        end
        if (rsp_o.entry_mask !== want_rsp.entry_mask) begin
          $error("entry_mask mismatch: expected %h, got %h",
                 want_rsp.entry_mask, rsp_o.entry_mask);
          failures++;
        end
        if (rsp_o.entry_gateway !== want_rsp.entry_gateway) begin
          $error("entry_gateway mismatch: expected %h, got %h",
                 want_rsp.entry_gateway, rsp_o.entry_gateway);
          failures++;
        end
        if (rsp_o.entry_port !== want_rsp.entry_port) begin
          $error("entry_port mismatch: expected %h, got %h",
                 want_rsp.entry_port, rsp_o.entry_port);
          failures++;
        end
        if (rsp_o.entry_count !== want_rsp.entry_count) begin
          $error("entry_count mismatch: expected %0d, got %0d",
                 want_rsp.entry_count, rsp_o.entry_count);
          failures++;
        end
      end
    end
  end

  // Watchdog: cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    wait (quiet_cycles >= WatchdogLimit);
    $display("Timeout: no transaction for %0d cycles, %0d responses outstanding",
             WatchdogLimit, expected_rsp.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_PORT0_ADDRESS;
    cfg_wdata_i <= '0;
    no_idle      = 1'b0;
    stall_sink   = 1'b0;
    route_count  = '0;
    for (int i = 0; i < TableEntries; i++) begin
      slot_used[i] = 1'b0;
    end
    for (int p = 0; p < 2; p++) begin
      port_addr[p] = '0;
      port_msk[p]  = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with an ordinary /8 and /24 pair of interfaces.
    program_ports(32'h0A00_0001, 32'hFF00_0000, 32'hC0A8_0101, 32'hFFFF_FF00);
    test_empty_table();
    test_add_routes();
    test_longest_match();
    test_default_routes();
    test_delete_routes();
    test_interface_change();

    // Random part. The table starts nearly empty, so the first run is heavy
    // on adds and soon meets a full table.
    test_random_mix(60, 70, 10, 15);

    settle_block();
    program_ports($urandom, contiguous_mask($urandom_range(1, 31)),
                  $urandom, contiguous_mask($urandom_range(1, 31)));
    test_random_mix(120, 35, 30, 30);
    test_back_to_back();
    test_output_backpressure();

    // Host masks: only the exact interface address reaches either side.
    settle_block();
    program_ports($urandom, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF);
    test_random_mix(100, 30, 40, 25);

    // Empty masks: every gateway is reachable through interface zero.
    settle_block();
    program_ports($urandom, 32'h0000_0000, $urandom, 32'h0000_0000);
    test_random_mix(100, 60, 10, 25);
    test_random_mix(100, 10, 60, 25);

    settle_block();
    if (expected_rsp.size() != 0) begin
      $error("%0d expected responses never arrived", expected_rsp.size());
      failures++;
    end

    $display("Sent %0d route operations and checked %0d responses under five port settings.",
             ops_sent, responses_checked);
    $display("Outcomes: ok %0d, not found %0d, unreachable %0d, duplicate %0d, full %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_UNREACHABLE],
             status_seen[ST_DUPLICATE], status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rtpm_pkg.sv
src/rtpm_cell.sv
src/routing_table_prefix_match.sv
tb/tb_routing_table_prefix_match.sv
